>>> rtl/core/ppd_pkg.sv
package ppd_pkg;

  // Detector phase codes, as reported on the result channel
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_THR = 1'b0;
  localparam logic CFG_GAP = 1'b1;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 15;
  localparam int GAP_W    = 16;
  localparam int RATE_W   = 11;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 16;

  // Rate = RATE_NUM / interval when the interval exceeds RATE_MIN_IVL ms
  localparam int RATE_NUM_W = 20;
  localparam logic [RATE_NUM_W-1:0] RATE_NUM = 20'd600000;
  localparam logic [TIME_W-1:0] RATE_MIN_IVL = 32'd300;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0] THR_RESET = 15'd80;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd400;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

endpackage

>>> rtl/core/ppd_rate_div.sv
// Restoring divider: quotient = RATE_NUM / divisor, one quotient bit a cycle.
module ppd_rate_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ppd_pkg::TIME_W-1:0]       divisor,
  output logic                             done,
  output logic [ppd_pkg::RATE_W-1:0]       quotient
);

  localparam int NW = ppd_pkg::RATE_NUM_W;
  localparam int CW = $clog2(NW + 1);

  logic [ppd_pkg::TIME_W-1:0] den_r;
  logic [ppd_pkg::TIME_W-1:0] rem_r;
  logic [NW-1:0]              num_r;
  logic [NW-1:0]              quo_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ppd_pkg::TIME_W:0]   rem_sh;
  logic [ppd_pkg::TIME_W:0]   rem_sub;
  logic                       q_bit;

  // One restoring step: shift in the next dividend bit, try a subtract
  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    q_bit   = (rem_sh >= {1'b0, den_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= '0;
      num_r <= ppd_pkg::RATE_NUM;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= q_bit ? rem_sub[ppd_pkg::TIME_W-1:0] : rem_sh[ppd_pkg::TIME_W-1:0];
      num_r <= {num_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], q_bit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[ppd_pkg::RATE_W-1:0];

endmodule

>>> rtl/core/pressure_pulse_detector_core.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   pressure_sample, sample_time_ms
// out_      output     out_valid/out_stall systolic, diastolic, rate, total, flags
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// One request at a time; the output register loads in FIN. An accepted request
// goes straight to FIN while the window fills, else through SCAN (one read per
// entry) and DECIDE, plus DIV when an accepted peak updates the rate (bit-serial divide).
// Sync active-low reset clears control and counts; the window is not cleared,
// being read only after every entry is written. in_stall is high while a
// request is in work; a result held by out_stall delays only the next result.
module pressure_pulse_detector_core #(
  parameter int WINDOW = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ppd_pkg::SAMPLE_W-1:0] in_pressure_sample,
  input  logic [ppd_pkg::TIME_W-1:0]        in_sample_time_ms,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ppd_pkg::SAMPLE_W-1:0] out_systolic_value,
  output logic signed [ppd_pkg::SAMPLE_W-1:0] out_diastolic_value,
  output logic [ppd_pkg::RATE_W-1:0]        out_rate_tenths_bpm,
  output logic [ppd_pkg::COUNT_W-1:0]       out_pulse_total,
  output logic                              out_new_reading,
  output logic [1:0]                        out_detector_phase,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [ppd_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int SW = ppd_pkg::SAMPLE_W;
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SUMW = SW + 1 + AW;
  localparam int MW = SUMW + 2;
  localparam logic signed [MW-1:0] WIN_S = MW'(WINDOW);

  ppd_pkg::state_t state_r;

  // configuration registers
  logic [ppd_pkg::THR_W-1:0] thr_r;
  logic [ppd_pkg::GAP_W-1:0] gap_r;

  // window memory and its pointers
  logic signed [SW-1:0] win_mem [WINDOW];
  logic signed [SW-1:0] rd_data_r;
  logic [AW-1:0]        wp_r;
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        fill_nxt;
  logic [AW:0]          scan_cnt_r;
  logic                 rd_vld_r;
  logic                 rd_first_r;
  logic                 issue;
  logic                 in_acc;

  // latched request
  logic signed [SW-1:0]      x_r;
  logic [ppd_pkg::TIME_W-1:0] now_r;

  // window statistics
  logic signed [SW-1:0]   max_r;
  logic signed [SW-1:0]   min_r;
  logic signed [SUMW-1:0] sum_r;

  // detector state
  logic [1:0]                 phase_r;
  logic signed [SW-1:0]       peak_r;
  logic signed [SW-1:0]       valley_r;
  logic [ppd_pkg::TIME_W-1:0] peak_time_r;
  logic [ppd_pkg::TIME_W-1:0] valley_time_r;
  logic [ppd_pkg::RATE_W-1:0] rate_r;
  logic [ppd_pkg::COUNT_W-1:0] pulse_r;
  logic                       fresh_r;

  // decision terms
  logic signed [SW+2:0]       thr_s;
  logic signed [SW+2:0]       x_e;
  logic signed [SW+2:0]       max_e;
  logic signed [SW+2:0]       min_e;
  logic                       fall_hit;
  logic                       rise_hit;
  logic                       mean_hit;
  logic                       gap_ok;
  logic [ppd_pkg::TIME_W-1:0] ivl;
  logic                       rate_upd;
  logic signed [MW-1:0]       lhs;
  logic signed [MW-1:0]       rhs;

  logic                       div_start;
  logic                       div_done;
  logic [ppd_pkg::RATE_W-1:0] div_q;
  logic                       out_load;

  assign in_stall = (state_r != ppd_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fill_nxt = (fill_r < FW'(WINDOW)) ? fill_r + 1'b1 : fill_r;
  assign issue    = (state_r == ppd_pkg::ST_SCAN) && (scan_cnt_r < (AW + 1)'(WINDOW));
  assign out_load = (state_r == ppd_pkg::ST_FIN) && (!out_valid || !out_stall);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ppd_pkg::THR_RESET;
      gap_r <= ppd_pkg::GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppd_pkg::CFG_THR: thr_r <= cfg_wdata[ppd_pkg::THR_W-1:0];
        ppd_pkg::CFG_GAP: gap_r <= cfg_wdata[ppd_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // window memory: write on accept, read during the scan
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_mem[wp_r] <= in_pressure_sample;
    end
    rd_data_r <= win_mem[scan_cnt_r[AW-1:0]];
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_pressure_sample;
      now_r <= in_sample_time_ms;
    end
  end

  // scan pipeline: max, min and sum over all entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      rd_vld_r   <= issue;
      rd_first_r <= issue && (scan_cnt_r == '0);
      if (in_acc) begin
        scan_cnt_r <= '0;
      end else if (issue) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (rd_first_r) begin
        max_r <= rd_data_r;
        min_r <= rd_data_r;
        sum_r <= SUMW'(rd_data_r);
      end else begin
        if (rd_data_r > max_r) max_r <= rd_data_r;
        if (rd_data_r < min_r) min_r <= rd_data_r;
        sum_r <= sum_r + SUMW'(rd_data_r);
      end
    end
  end

  // detection terms
  always_comb begin
    thr_s    = (SW + 3)'($signed({1'b0, thr_r}));
    x_e      = (SW + 3)'(x_r);
    max_e    = (SW + 3)'(max_r);
    min_e    = (SW + 3)'(min_r);
    fall_hit = x_e < (max_e - thr_s);
    rise_hit = x_e > (min_e + thr_s);
    lhs      = MW'(x_r) * WIN_S;
    rhs      = MW'(sum_r) + MW'($signed({1'b0, thr_r})) * WIN_S;
    mean_hit = lhs > rhs;
    gap_ok   = (now_r - peak_time_r) >= ppd_pkg::TIME_W'(gap_r);
    ivl      = now_r - valley_time_r;
    rate_upd = (phase_r == ppd_pkg::PH_RISE) && fall_hit && gap_ok &&
               (ivl > ppd_pkg::RATE_MIN_IVL);
  end

  assign div_start = (state_r == ppd_pkg::ST_DECIDE) && rate_upd;

  ppd_rate_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (ivl),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ppd_pkg::ST_IDLE;
      wp_r          <= '0;
      fill_r        <= '0;
      phase_r       <= ppd_pkg::PH_IDLE;
      peak_r        <= '0;
      valley_r      <= '0;
      peak_time_r   <= '0;
      valley_time_r <= '0;
      rate_r        <= '0;
      pulse_r       <= '0;
      fresh_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ppd_pkg::ST_IDLE: begin
          if (in_acc) begin
            wp_r    <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
            fill_r  <= fill_nxt;
            fresh_r <= 1'b0;
            state_r <= (fill_nxt == FW'(WINDOW)) ? ppd_pkg::ST_SCAN : ppd_pkg::ST_FIN;
          end
        end
        ppd_pkg::ST_SCAN: begin
          if (!issue && !rd_vld_r) begin
            state_r <= ppd_pkg::ST_DECIDE;
          end
        end
        ppd_pkg::ST_DECIDE: begin
          state_r <= rate_upd ? ppd_pkg::ST_DIV : ppd_pkg::ST_FIN;
          unique case (phase_r)
            ppd_pkg::PH_RISE: begin
              if (fall_hit) begin
                if (gap_ok) begin
                  peak_r      <= max_r;
                  peak_time_r <= now_r;
                  pulse_r     <= pulse_r + 1'b1;
                end
                phase_r <= ppd_pkg::PH_FALL;
              end
            end
            ppd_pkg::PH_FALL: begin
              if (rise_hit) begin
                valley_r      <= min_r;
                valley_time_r <= now_r;
                phase_r       <= ppd_pkg::PH_RISE;
                fresh_r       <= 1'b1;
              end
            end
            default: begin
              // idle, and the unused code treated as idle
              if (mean_hit) begin
                phase_r       <= ppd_pkg::PH_RISE;
                valley_r      <= min_r;
                valley_time_r <= now_r;
              end
            end
          endcase
        end
        ppd_pkg::ST_DIV: begin
          if (div_done) begin
            rate_r  <= div_q;
            state_r <= ppd_pkg::ST_FIN;
          end
        end
        ppd_pkg::ST_FIN: begin
          if (out_load) begin
            state_r <= ppd_pkg::ST_IDLE;
          end
        end
        default: state_r <= ppd_pkg::ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_systolic_value  <= peak_r;
      out_diastolic_value <= valley_r;
      out_rate_tenths_bpm <= rate_r;
      out_pulse_total     <= pulse_r;
      out_new_reading     <= fresh_r;
      out_detector_phase  <= phase_r;
    end
  end

endmodule
